@@ hdl/lolt_pkg.sv @@
package lolt_pkg;

  localparam int LOLT_SLOTS = 8;

  // Commands carried by an input item
  localparam logic [1:0] CMD_QUERY   = 2'd0;
  localparam logic [1:0] CMD_FAIL    = 2'd1;
  localparam logic [1:0] CMD_SUCCESS = 2'd2;

  // Register indexes on the configuration port
  localparam logic REG_LOCK_LIMIT = 1'b0;
  localparam logic REG_LOCK_TIME  = 1'b1;

  localparam logic [7:0]  LOCK_LIMIT_RESET = 8'd5;
  localparam logic [15:0] LOCK_TIME_RESET  = 16'd60;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] source_key;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic        blocked;
    logic [15:0] retry_after;
    logic        lock_started;
  } out_item_t;

  // One table entry as it travels round the ring
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [7:0]  fail_count;
    logic [31:0] deadline;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_WRITE,
    ST_FINISH
  } state_t;

endpackage

@@ hdl/lolt_cell.sv @@
module lolt_cell
  import lolt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        shift,
  input  entry_t      d,
  output entry_t      q
);

  entry_t entry;

  // Take the neighbour's entry on every shift
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (shift) begin
      entry <= d;
    end
  end

  assign q = entry;

endmodule

@@ hdl/login_lockout_table.sv @@
// Failed-login lockout table. Each item holds a command (query, failure,
// success), a 32-bit source key and the current time in seconds, and yields
// exactly one result item. The SLOTS entries sit in a ring of cells that
// rotates one place per clock while scanning or writing back; the head cell
// is inspected as each entry passes, so one scan pass round the ring finds the
// match, the first free slot and the entry with the least deadline, a
// calculation state works out the update and a second pass writes the changed
// entry back. The write pass is taken only when an item changes an entry (a
// failure, or a success that finds its source). An item is accepted only after
// the one before it has loaded its result into the output register.
// A finished result waits in the output register while the next item is taken
// in. lock_limit sits at byte address 0 and lock_time at byte address 4; both
// may be written only while no item is in flight.
module login_lockout_table
  import lolt_pkg::*;
#(
  parameter int SLOTS = LOLT_SLOTS
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(SLOTS);

  // Configuration registers
  logic [7:0]  lock_limit;
  logic [15:0] lock_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_limit <= LOCK_LIMIT_RESET;
      lock_time  <= LOCK_TIME_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_LOCK_LIMIT: lock_limit <= pwdata[7:0];
        REG_LOCK_TIME:  lock_time  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LOCK_TIME) ? {16'd0, lock_time} : {24'd0, lock_limit};

  // Control state
  state_t           state, state_next;
  logic [IDX_W-1:0] cnt;
  logic             cnt_last;
  in_item_t         item;
  logic             shift;
  logic             write_needed;
  logic             out_load;

  // Scan results
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic [7:0]       hit_count;
  logic [31:0]      hit_deadline;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] least_idx;
  logic [31:0]      least_dl;

  // Update worked out in the calculation cycle
  logic [IDX_W-1:0] tgt_idx;
  entry_t           new_entry;
  out_item_t        result;

  // Ring of cells
  entry_t cell_q [SLOTS];
  entry_t cell_d [SLOTS];
  logic   head_hit;
  entry_t wrap;

  assign wrap = (state == ST_WRITE && cnt == tgt_idx) ? new_entry : cell_q[0];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS - 1) begin : g_tail
      assign cell_d[i] = wrap;
    end else begin : g_body
      assign cell_d[i] = cell_q[i+1];
    end
    lolt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (cell_d[i]),
      .q     (cell_q[i])
    );
  end

  // Flag a valid head entry holding the probed source
  assign head_hit = cell_q[0].valid && (cell_q[0].key == item.source_key);

  assign cnt_last = (cnt == IDX_W'(SLOTS - 1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SCAN;
      ST_SCAN:   if (cnt_last) state_next = ST_CALC;
      ST_CALC:   state_next = write_needed ? ST_WRITE : ST_FINISH;
      ST_WRITE:  if (cnt_last) state_next = ST_FINISH;
      ST_FINISH: if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall = 1'b1;
    shift    = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_SCAN:   shift = 1'b1;
      ST_WRITE:  shift = 1'b1;
      ST_FINISH: out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state != state_next) begin
        cnt <= '0;
      end else if (shift) begin
        cnt <= cnt + IDX_W'(1);
      end
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      item <= in_item;
    end
  end

  // Track match, first free slot and least deadline as entries pass the head
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (state == ST_IDLE) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (head_hit && !hit_found) begin
        hit_found <= 1'b1;
      end
      if (!cell_q[0].valid && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      if (head_hit && !hit_found) begin
        hit_idx      <= cnt;
        hit_count    <= cell_q[0].fail_count;
        hit_deadline <= cell_q[0].deadline;
      end
      if (!cell_q[0].valid && !free_found) begin
        free_idx <= cnt;
      end
      if (cnt == '0 || cell_q[0].deadline < least_dl) begin
        least_idx <= cnt;
        least_dl  <= cell_q[0].deadline;
      end
    end
  end

  // Work out the result and the changed entry
  logic [31:0] base_dl;
  logic [7:0]  base_count;
  logic        expired;
  logic [7:0]  count_run;
  logic [7:0]  count_inc;
  logic [32:0] dl_sum;
  logic [31:0] dl_sat;
  logic [31:0] left;
  logic        reach;
  out_item_t   result_next;

  always_comb begin
    base_dl    = hit_found ? hit_deadline : 32'd0;
    base_count = hit_found ? hit_count : 8'd0;
    expired    = (base_dl != 32'd0) && (base_dl <= item.now_seconds);
    count_run  = expired ? 8'd0 : base_count;
    count_inc  = (count_run == 8'hFF) ? 8'hFF : count_run + 8'd1;
    reach      = (count_inc >= lock_limit);
    dl_sum     = {1'b0, item.now_seconds} + {17'd0, lock_time};
    dl_sat     = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
    left       = hit_deadline - item.now_seconds;
    result_next = '0;
    if (item.cmd == CMD_QUERY && hit_found && hit_deadline > item.now_seconds) begin
      result_next.blocked     = 1'b1;
      result_next.retry_after = (|left[31:16]) ? 16'hFFFF : left[15:0];
    end
    if (item.cmd == CMD_FAIL && reach) begin
      result_next.lock_started = 1'b1;
    end
  end

  // The write decision is combinational on the scan results
  assign write_needed = (item.cmd == CMD_FAIL) || (item.cmd == CMD_SUCCESS && hit_found);

  always_ff @(posedge clk) begin
    if (state == ST_CALC) begin
      result          <= result_next;
      tgt_idx         <= hit_found ? hit_idx : (free_found ? free_idx : least_idx);
      new_entry.valid <= 1'b1;
      new_entry.key   <= item.source_key;
      case (item.cmd)
        CMD_FAIL: begin
          if (reach) begin
            new_entry.fail_count <= 8'd0;
            new_entry.deadline   <= dl_sat;
          end else begin
            new_entry.fail_count <= count_inc;
            new_entry.deadline   <= expired ? 32'd0 : base_dl;
          end
        end
        default: begin
          new_entry.fail_count <= 8'd0;
          new_entry.deadline   <= 32'd0;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item <= result;
    end
  end

endmodule

@@ tb/tb_login_lockout_table.sv @@
module tb_login_lockout_table;
  import lolt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = LOLT_SLOTS;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 2 * SLOTS + 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted table and register copies
  logic        slot_valid[SLOTS];
  logic [31:0] slot_key[SLOTS];
  logic [7:0]  slot_count[SLOTS];
  logic [31:0] slot_deadline[SLOTS];
  logic [7:0]  limit_now;
  logic [15:0] lock_now;

  out_item_t   expected_verdicts[$];
  out_item_t   next_verdict;
  int          mismatches = 0;
  int          cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Random traffic state
  logic [31:0] key_pool[12];
  logic [31:0] last_key = '0;
  logic [31:0] clock_now = 32'd100;

  login_lockout_table dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  task automatic reset_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i] = '0;
      slot_count[i] = '0;
      slot_deadline[i] = '0;
    end
    limit_now = LOCK_LIMIT_RESET;
    lock_now = LOCK_TIME_RESET;
  endtask

  // Advance the predicted table by one item and return its verdict
  function automatic out_item_t predict_lockout(in_item_t it);
    out_item_t   res;
    int          hit;
    int          spare;
    int          least;
    logic [31:0] left;
    logic [32:0] sum;
    res = '0;
    hit = -1;
    for (int i = 0; i < SLOTS; i++)
      if (hit < 0 && slot_valid[i] && slot_key[i] == it.source_key) hit = i;
    case (it.cmd)
      CMD_QUERY: begin
        if (hit >= 0 && slot_deadline[hit] > it.now_seconds) begin
          left = slot_deadline[hit] - it.now_seconds;
          res.blocked = 1'b1;
          res.retry_after = (left > 32'hFFFF) ? 16'hFFFF : left[15:0];
        end
      end
      CMD_FAIL: begin
        // Allocate: first free slot, else the least deadline
        if (hit < 0) begin
          spare = -1;
          least = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (!slot_valid[i] && spare < 0) spare = i;
            if (slot_deadline[i] < slot_deadline[least]) least = i;
          end
          if (spare < 0) spare = least;
          slot_valid[spare] = 1'b1;
          slot_key[spare] = it.source_key;
          slot_count[spare] = '0;
          slot_deadline[spare] = '0;
          hit = spare;
        end
        // Drop an expired lock before counting
        if (slot_deadline[hit] != 0 && slot_deadline[hit] <= it.now_seconds) begin
          slot_count[hit] = '0;
          slot_deadline[hit] = '0;
        end
        if (slot_count[hit] != 8'hFF) slot_count[hit]++;
        if (slot_count[hit] >= limit_now) begin
          sum = {1'b0, it.now_seconds} + {17'b0, lock_now};
          slot_deadline[hit] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          slot_count[hit] = '0;
          res.lock_started = 1'b1;
        end
      end
      CMD_SUCCESS: begin
        if (hit >= 0) begin
          slot_count[hit] = '0;
          slot_deadline[hit] = '0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Compare each delivered result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_item));
      end else begin
        next_verdict = expected_verdicts.pop_front();
        if (out_item.blocked !== next_verdict.blocked ||
            out_item.retry_after !== next_verdict.retry_after ||
            out_item.lock_started !== next_verdict.lock_started)
          report_mismatch($sformatf("expected blocked=%0d retry=%0d lock=%0d, got %0d %0d %0d",
                                    next_verdict.blocked, next_verdict.retry_after,
                                    next_verdict.lock_started, out_item.blocked,
                                    out_item.retry_after, out_item.lock_started));
      end
    end
  end

  // Offer one item, idling first at random, and record its verdict once taken
  task automatic send_login(input logic [1:0] cmd, input logic [31:0] key,
                            input logic [31:0] now);
    in_item_t it;
    it.cmd = cmd;
    it.source_key = key;
    it.now_seconds = now;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    expected_verdicts.push_back(predict_lockout(it));
  endtask

  // Hold off until every verdict is in and the table has settled
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic reg_idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_LOCK_LIMIT) limit_now = value[7:0];
    else lock_now = value[15:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_register(input logic reg_idx);
    logic [31:0] want;
    logic [31:0] got;
    want = (reg_idx == REG_LOCK_LIMIT) ? {24'b0, limit_now} : {16'b0, lock_now};
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {reg_idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = (reg_idx == REG_LOCK_LIMIT) ? {24'b0, prdata[7:0]} : {16'b0, prdata[15:0]};
    if (got !== want)
      report_mismatch($sformatf("register %0d read %0h, expected %0h", reg_idx, got, want));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_policy(input logic [7:0] limit, input logic [15:0] lock);
    apb_write(REG_LOCK_LIMIT, {24'b0, limit});
    apb_write(REG_LOCK_TIME, {16'b0, lock});
  endtask

  // Draw a login event: streaks from one source, a small pool, some strangers
  task automatic random_login();
    int unsigned pick;
    int unsigned warp;
    logic [1:0]  cmd;
    logic [31:0] now;
    pick = $urandom_range(0, 99);
    if (pick >= 88) last_key = $urandom;
    else if (pick >= 50) last_key = key_pool[$urandom_range(0, 11)];
    pick = $urandom_range(0, 99);
    cmd = (pick < 45) ? CMD_FAIL : (pick < 80) ? CMD_QUERY : CMD_SUCCESS;
    clock_now += $urandom_range(0, lock_now / 3 + 1);
    warp = $urandom_range(0, 99);
    if (warp < 4) clock_now = $urandom;
    if (clock_now == 0) clock_now = 1;
    now = clock_now;
    if (warp >= 4 && warp < 12) now = $urandom;
    else if (warp >= 12 && warp < 18) now = clock_now - $urandom_range(0, 70000);
    if (now == 0) now = 1;
    send_login(cmd, last_key, now);
  endtask

  task automatic test_register_access();
    check_register(REG_LOCK_LIMIT);
    check_register(REG_LOCK_TIME);
    set_policy(8'd255, 16'd65535);
    check_register(REG_LOCK_LIMIT);
    check_register(REG_LOCK_TIME);
    set_policy(8'd1, 16'd1);
    check_register(REG_LOCK_LIMIT);
    check_register(REG_LOCK_TIME);
  endtask

  task automatic test_directed_cases();
    wait_drained();
    set_policy(8'd2, 16'd100);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // Unknown source: query and success leave nothing behind
    send_login(CMD_QUERY, 32'h0, 32'd1);
    send_login(CMD_SUCCESS, 32'h0, 32'd2);
    // Lock, query while locked, query exactly at the deadline
    send_login(CMD_FAIL, 32'h0, 32'd1000);
    send_login(CMD_FAIL, 32'h0, 32'd1001);
    send_login(CMD_QUERY, 32'h0, 32'd1001);
    send_login(CMD_QUERY, 32'h0, 32'd1101);
    // Expired lock is cleared by the next failure, success clears the entry
    send_login(CMD_FAIL, 32'h0, 32'd1200);
    send_login(CMD_SUCCESS, 32'h0, 32'd1200);
    // Deadline saturates near the top of time, long wait saturates retry
    send_login(CMD_FAIL, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    send_login(CMD_FAIL, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    send_login(CMD_QUERY, 32'hFFFF_FFFF, 32'd1);
    send_login(CMD_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Fill the table, then evict the least deadline
    for (int k = 1; k <= 6; k++) send_login(CMD_FAIL, 32'h1000 + k, 32'd2000 + k);
    send_login(CMD_FAIL, 32'hA5A5_5A5A, 32'd3000);
    send_login(CMD_QUERY, 32'h0, 32'd3001);
    send_login(CMD_SUCCESS, 32'hA5A5_5A5A, 32'd3002);
  endtask

  task automatic test_fail_limit_ceiling();
    wait_drained();
    set_policy(8'd255, 16'd65535);
    send_idle_pct = 0;
    recv_stall_pct = 26;
    for (int k = 0; k < 256; k++) send_login(CMD_FAIL, 32'h5EED_0001, 32'd5000 + k);
    send_login(CMD_QUERY, 32'h5EED_0001, 32'd5300);
  endtask

  task automatic test_random_traffic(input int count, input int unsigned idle_pct,
                                     input int unsigned stall_pct, input logic [7:0] limit,
                                     input logic [15:0] lock, input bit pause_midway);
    wait_drained();
    set_policy(limit, lock);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) wait_drained();
      random_login();
    end
  endtask

  initial begin
    reset_table();
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 12; i++) key_pool[i] = $urandom;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_register_access();
    test_directed_cases();
    test_fail_limit_ceiling();
    test_random_traffic(260, 0, 0, 8'd1, 16'd1, 1'b0);
    test_random_traffic(260, 64, 0, 8'd3, 16'd65535, 1'b1);
    test_random_traffic(260, 0, 64, 8'd4, 16'd500, 1'b0);
    test_random_traffic(260, 26, 26, 8'($urandom_range(1, 8)),
                        16'($urandom_range(1, 65535)), 1'b0);
    wait_drained();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
